// File: rtl/tod_pkg.sv
// Shared types and codes of the TCP option decoder.
// Holds the channel payload structs, parse phase enum and record kind codes.
// No dependencies.
package tod_pkg;

	// Option kind bytes as they appear on the wire
	localparam logic [7:0] OPT_EOL    = 8'd0;
	localparam logic [7:0] OPT_NOP    = 8'd1;
	localparam logic [7:0] OPT_MSS    = 8'd2;
	localparam logic [7:0] OPT_WSCALE = 8'd3;
	localparam logic [7:0] OPT_SACKOK = 8'd4;
	localparam logic [7:0] OPT_SACK   = 8'd5;
	localparam logic [7:0] OPT_TSTAMP = 8'd8;

	// Shortest legal SACK length (kind and length bytes only)
	localparam logic [7:0] SACK_HDR_LEN = 8'd2;
	// Bytes in one MSS value
	localparam logic [7:0] MSS_DATA_LEN = 8'd2;
	// Byte position that completes a pair of 32-bit words
	localparam logic [2:0] LAST_PAIR_POS = 3'd7;

	// Record kinds
	localparam logic [3:0] RK_EOL   = 4'd0;
	localparam logic [3:0] RK_NOP   = 4'd1;
	localparam logic [3:0] RK_MSS   = 4'd2;
	localparam logic [3:0] RK_WS    = 4'd3;
	localparam logic [3:0] RK_SOK   = 4'd4;
	localparam logic [3:0] RK_SACKH = 4'd5;
	localparam logic [3:0] RK_SACKB = 4'd6;
	localparam logic [3:0] RK_SACKM = 4'd7;
	localparam logic [3:0] RK_TS    = 4'd8;
	localparam logic [3:0] RK_FAIL  = 4'd9;

	typedef enum logic [3:0] {
		PH_KIND      = 4'd0,
		PH_MSS_LEN   = 4'd1,
		PH_MSS_DATA  = 4'd2,
		PH_WS_LEN    = 4'd3,
		PH_WS_DATA   = 4'd4,
		PH_SOK_LEN   = 4'd5,
		PH_SACK_LEN  = 4'd6,
		PH_SACK_SKIP = 4'd7,
		PH_SACK_BLK  = 4'd8,
		PH_TS_LEN    = 4'd9,
		PH_TS_DATA   = 4'd10
	} phase_t;

	typedef struct packed {
		logic [7:0] opt_byte;
		logic       last_byte;
	} opt_item_t;

	typedef struct packed {
		logic [3:0]  record_kind;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic        list_end;
		logic        list_ok;
	} rec_item_t;

	// Result of one parse step toward the output slot
	typedef struct packed {
		logic      emit;
		rec_item_t rec;
	} parse_res_t;

endpackage

// File: rtl/tod_parse.sv
// Parse state of the TCP option decoder and its per-byte update logic.
// Holds phase, byte counters and the word accumulators; depends on tod_pkg.
module tod_parse import tod_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  opt_item_t  item,
	output parse_res_t res
);

	phase_t      phase_q, phase_n;
	logic [7:0]  bytes_left_q, bytes_left_n;
	logic [2:0]  block_pos_q, block_pos_n;
	logic [31:0] word_first_q, word_first_n;
	logic [31:0] word_second_q, word_second_n;
	logic        failed_q, failed_n;

	logic        have;
	logic        ok;
	logic [3:0]  kind;
	logic [31:0] va;
	logic [31:0] vb;
	logic [7:0]  byte_in;
	logic [7:0]  sack_len;
	logic [7:0]  left_dec;

	always_comb begin
		byte_in       = item.opt_byte;
		sack_len      = byte_in - SACK_HDR_LEN;
		left_dec      = bytes_left_q - 8'd1;
		phase_n       = phase_q;
		bytes_left_n  = bytes_left_q;
		block_pos_n   = block_pos_q;
		word_first_n  = word_first_q;
		word_second_n = word_second_q;
		failed_n      = failed_q;
		have          = 1'b0;
		kind          = RK_EOL;
		va            = '0;
		vb            = '0;

		if (!failed_q) begin
			unique case (phase_q)
				PH_KIND: begin
					word_first_n  = '0;
					word_second_n = '0;
					block_pos_n   = '0;
					unique case (byte_in)
						OPT_EOL: begin
							have = 1'b1;
							kind = RK_EOL;
						end
						OPT_NOP: begin
							have = 1'b1;
							kind = RK_NOP;
						end
						OPT_MSS:    phase_n = PH_MSS_LEN;
						OPT_WSCALE: phase_n = PH_WS_LEN;
						OPT_SACKOK: phase_n = PH_SOK_LEN;
						OPT_SACK:   phase_n = PH_SACK_LEN;
						OPT_TSTAMP: phase_n = PH_TS_LEN;
						default:    failed_n = 1'b1;
					endcase
				end
				PH_MSS_LEN: begin
					phase_n      = PH_MSS_DATA;
					bytes_left_n = MSS_DATA_LEN;
				end
				PH_MSS_DATA: begin
					word_first_n = {word_first_q[23:0], byte_in};
					bytes_left_n = left_dec;
					if (left_dec == 8'd0) begin
						have    = 1'b1;
						kind    = RK_MSS;
						va      = {16'd0, word_first_n[15:0]};
						phase_n = PH_KIND;
					end
				end
				PH_WS_LEN: phase_n = PH_WS_DATA;
				PH_WS_DATA: begin
					have    = 1'b1;
					kind    = RK_WS;
					va      = {24'd0, byte_in};
					phase_n = PH_KIND;
				end
				PH_SOK_LEN: begin
					have    = 1'b1;
					kind    = RK_SOK;
					phase_n = PH_KIND;
				end
				PH_SACK_LEN: begin
					priority if (byte_in < SACK_HDR_LEN) begin
						failed_n = 1'b1;
					end else if (byte_in == SACK_HDR_LEN) begin
						have    = 1'b1;
						kind    = RK_SACKM;
						phase_n = PH_KIND;
					end else if (sack_len[2:0] != 3'd0) begin
						// ragged block area: skip it, flag malformed at its end
						bytes_left_n = sack_len;
						phase_n      = PH_SACK_SKIP;
					end else begin
						have         = 1'b1;
						kind         = RK_SACKH;
						va           = {27'd0, sack_len[7:3]};
						bytes_left_n = sack_len;
						block_pos_n  = '0;
						phase_n      = PH_SACK_BLK;
					end
				end
				PH_SACK_SKIP: begin
					bytes_left_n = left_dec;
					if (left_dec == 8'd0) begin
						have    = 1'b1;
						kind    = RK_SACKM;
						phase_n = PH_KIND;
					end
				end
				PH_SACK_BLK: begin
					if (!block_pos_q[2])
						word_first_n = {word_first_q[23:0], byte_in};
					else
						word_second_n = {word_second_q[23:0], byte_in};
					if (block_pos_q == LAST_PAIR_POS) begin
						have          = 1'b1;
						kind          = RK_SACKB;
						va            = word_first_n;
						vb            = word_second_n;
						word_first_n  = '0;
						word_second_n = '0;
						block_pos_n   = '0;
					end else begin
						block_pos_n = block_pos_q + 3'd1;
					end
					bytes_left_n = left_dec;
					if (left_dec == 8'd0)
						phase_n = PH_KIND;
				end
				PH_TS_LEN: begin
					block_pos_n = '0;
					phase_n     = PH_TS_DATA;
				end
				PH_TS_DATA: begin
					if (!block_pos_q[2])
						word_first_n = {word_first_q[23:0], byte_in};
					else
						word_second_n = {word_second_q[23:0], byte_in};
					if (block_pos_q == LAST_PAIR_POS) begin
						have        = 1'b1;
						kind        = RK_TS;
						va          = word_first_n;
						vb          = word_second_n;
						block_pos_n = '0;
						phase_n     = PH_KIND;
					end else begin
						block_pos_n = block_pos_q + 3'd1;
					end
				end
				default: begin
					phase_n  = PH_KIND;
					failed_n = 1'b1;
				end
			endcase
		end

		ok = !failed_n && (phase_n == PH_KIND) && have;

		res.emit            = have || item.last_byte;
		res.rec.record_kind = kind;
		res.rec.value_a     = va;
		res.rec.value_b     = vb;
		res.rec.list_end    = item.last_byte;
		res.rec.list_ok     = item.last_byte && ok;
		if (item.last_byte && !ok) begin
			res.rec.record_kind = RK_FAIL;
			res.rec.value_a     = '0;
			res.rec.value_b     = '0;
		end

		// last byte closes the list: start the next one from scratch
		if (item.last_byte) begin
			phase_n       = PH_KIND;
			bytes_left_n  = '0;
			block_pos_n   = '0;
			word_first_n  = '0;
			word_second_n = '0;
			failed_n      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_KIND;
			bytes_left_q  <= '0;
			block_pos_q   <= '0;
			word_first_q  <= '0;
			word_second_q <= '0;
			failed_q      <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_n;
			bytes_left_q  <= bytes_left_n;
			block_pos_q   <= block_pos_n;
			word_first_q  <= word_first_n;
			word_second_q <= word_second_n;
			failed_q      <= failed_n;
		end
	end

endmodule

// File: rtl/tod_out_slot.sv
// Result register of the TCP option decoder.
// Holds one decoded record until the receiver takes it; depends on tod_pkg.
module tod_out_slot import tod_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  rec_item_t din,
	input  logic      ready,
	output logic      valid,
	output rec_item_t dout,
	output logic      free
);

	logic      valid_q;
	rec_item_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign dout  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load)
			data_q <= din;
	end

endmodule

// File: rtl/tcp_option_decoder.sv
// TCP option decoder: top level with the input register, parser and result slot.
// Depends on tod_pkg, tod_parse and tod_out_slot.
//
// Usage:
//   opt_valid/opt_ready/opt_item carry the option area one byte per
//   transaction; last_byte marks its final byte. rec_valid/rec_ready/rec_item
//   carry decoded records, at most one per byte; the last byte always gives
//   one record with list_end set, and list_ok clear if the list failed.
//   Path: the byte enters the input register at the edge that takes it; the
//   parser then reads it there, and its record enters the result register
//   once that register is free, which sets rec_valid.
//   Throughput: one byte per cycle, sustained while rec_ready holds; the
//   per-byte update of phase, counters and word shifters is combinational.
//   Reset: arst_n clears both stages and returns the parser to expect a kind
//   byte. A stalled receiver holds the result register; the parser and input
//   register then hold too, and opt_ready drops once the input register fills.
module tcp_option_decoder import tod_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      opt_valid,
	output logic      opt_ready,
	input  opt_item_t opt_item,
	output logic      rec_valid,
	input  logic      rec_ready,
	output rec_item_t rec_item
);

	logic       valid_s1;
	opt_item_t  item_s1;
	logic       out_free;
	logic       step;
	parse_res_t res;

	assign step      = valid_s1 && out_free;
	assign opt_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (opt_ready) begin
			valid_s1 <= opt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (opt_ready && opt_valid)
			item_s1 <= opt_item;
	end

	tod_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	tod_out_slot u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && res.emit),
		.din    (res.rec),
		.ready  (rec_ready),
		.valid  (rec_valid),
		.dout   (rec_item),
		.free   (out_free)
	);

	// a good list is only reported on its closing record
	a_ok_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_item.list_ok |-> rec_item.list_end)
		else $error("list_ok set on a record that does not close the list");

	a_fail_record: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_item.list_end && !rec_item.list_ok |->
		rec_item.record_kind == RK_FAIL && rec_item.value_a == '0 &&
		rec_item.value_b == '0)
		else $error("failed list did not close with a clean failure record");

	a_fail_kind_closes: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_item.record_kind == RK_FAIL |-> rec_item.list_end)
		else $error("failure record not marked as list end");

	// parser must hold while the result register is blocked
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |-> !step)
		else $error("parser advanced while the result register was stalled");

endmodule
